// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SKF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SKF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CHANNELS   = 2;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam int CFG_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_W-1:0] CFG_PROC_NOISE = CFG_W'(0);
    localparam logic [CFG_W-1:0] CFG_MEAS_NOISE = CFG_W'(1);
    localparam logic [CFG_W-1:0] CFG_INIT_EST   = CFG_W'(2);
    localparam logic [CFG_W-1:0] CFG_INIT_VAR   = CFG_W'(3);

    // reset values: 0.125, 32.0, 0.0, 1023.0
    localparam logic [DATA_WIDTH-1:0] Q_RESET  = DATA_WIDTH'(1) << (FRAC_BITS - 3);
    localparam logic [DATA_WIDTH-1:0] R_RESET  = DATA_WIDTH'(32) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] X0_RESET = '0;
    localparam logic [DATA_WIDTH-1:0] P0_RESET = DATA_WIDTH'(1023) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]    ONE_FIX  = (FRAC_BITS+1)'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample;
        logic                         channel;
        logic                         restart;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] estimate;
        logic        [DATA_WIDTH-1:0] variance;
        logic                         channel_out;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_MUL,
        S_UPD
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic prep;
        logic div_step;
        logic mul;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [DATA_WIDTH-1:0] sat_add(input logic [DATA_WIDTH-1:0] a,
                                                      input logic [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DATA_WIDTH] ? {DATA_WIDTH{1'b1}} : s[DATA_WIDTH-1:0];
    endfunction

    // state slot of a channel field: channel modulo CHANNELS
    function automatic logic [CH_W-1:0] ch_index(input logic ch);
        if (CHANNELS == 1) return '0;
        return CH_W'(ch);
    endfunction

endpackage

// File: rtl/scalar_kalman_filter_top.sv
`timescale 1ns / 1ps

// Two-channel scalar Kalman filter, Q16.16 fixed point.
// Input channel: i_in_valid / o_in_stall / i_in_item (sample, channel, restart).
// An item is taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall / o_out_item (estimate, variance,
// channel_out), one result per item.
// Each item passes the load, prepare, gain divide, multiply and update steps;
// the result shows on o_out_valid after the update step. The gain divider
// yields one quotient bit a cycle. A new item is taken only when idle again.
// The output register holds a finished result while the receiver stalls; the
// next item is taken meanwhile and waits in its update step until the output
// register is free. o_in_stall is low only while no item is in work.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write Q, R, initial
// estimate and initial variance, in that index order; write only while idle.
// Reset (synchronous, active low) loads the register defaults (0.125, 32.0,
// 0.0, 1023.0), sets both channels to estimate 0.0 and variance 1023.0 and
// empties the output register.
module scalar_kalman_filter_top import skf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    skf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// File: rtl/skf_ctrl.sv
`timescale 1ns / 1ps

module skf_ctrl import skf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                // one quotient bit per cycle
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/skf_dp.sv
`timescale 1ns / 1ps

module skf_dp import skf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;

    logic [DW-1:0] r_q, r_r, r_x0, r_p0;
    logic [DW-1:0] r_est [CHANNELS];
    logic [DW-1:0] r_var [CHANNELS];

    t_in_item              r_item;
    logic [CH_W-1:0]       r_ch;
    logic signed [DW-1:0]  r_x;
    logic [DW-1:0]         r_p1;
    logic [DW-1:0]         r_den;
    logic [DW:0]           r_mag;
    logic                  r_neg;
    logic                  r_kzero, r_kone;
    logic [DW-1:0]         r_rem;
    logic [FB-1:0]         r_quo;
    logic [DW+FB+1:0]      r_sprod;
    logic [DW+FB:0]        r_vprod;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic signed [DW:0]    diff;
    logic [DW:0]           rem_sh;
    logic [FB:0]           k;
    logic [FB:0]           one_minus_k;
    logic [DW:0]           step;
    logic [DW+1:0]         x_wide;
    logic [DW+1:0]         x_next;
    logic                  out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q  <= Q_RESET;
            r_r  <= R_RESET;
            r_x0 <= X0_RESET;
            r_p0 <= P0_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROC_NOISE: r_q  <= i_cfg_data;
                CFG_MEAS_NOISE: r_r  <= i_cfg_data;
                CFG_INIT_EST:   r_x0 <= i_cfg_data;
                CFG_INIT_VAR:   r_p0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign diff   = $signed({r_item.sample[DW-1], r_item.sample}) - $signed({r_x[DW-1], r_x});
    assign rem_sh = {r_rem, 1'b0};

    always_comb begin
        if (r_kzero) begin
            k = '0;
        end else if (r_kone) begin
            k = ONE_FIX;
        end else begin
            k = {1'b0, r_quo};
        end
    end
    assign one_minus_k = ONE_FIX - k;

    assign step   = r_sprod[DW+FB:FB];
    assign x_wide = {{2{r_x[DW-1]}}, r_x};
    assign x_next = r_neg ? (x_wide - {1'b0, step}) : (x_wide + {1'b0, step});

    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
            r_ch   <= ch_index(i_in_item.channel);
        end
        if (i_cmd.load) begin
            if (r_item.restart) begin
                r_x  <= r_x0;
                r_p1 <= sat_add(r_p0, r_q);
            end else begin
                r_x  <= r_est[r_ch];
                r_p1 <= sat_add(r_var[r_ch], r_q);
            end
        end
        if (i_cmd.prep) begin
            r_den   <= sat_add(r_p1, r_r);
            r_neg   <= diff[DW];
            r_mag   <= diff[DW] ? (DW+1)'(-diff) : diff;
            // denominator zero only when both terms are zero; gain one when P1 >= P1+R
            r_kzero <= (r_p1 == '0) && (r_r == '0);
            r_kone  <= (r_r == '0) || (r_p1 == {DW{1'b1}});
            r_rem   <= r_p1;
            r_quo   <= '0;
        end
        if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= DW'(rem_sh - {1'b0, r_den});
                r_quo <= {r_quo[FB-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DW-1:0];
                r_quo <= {r_quo[FB-2:0], 1'b0};
            end
        end
        if (i_cmd.mul) begin
            r_sprod <= r_mag * k;
            r_vprod <= r_p1 * one_minus_k;
        end
        if (i_cmd.upd) begin
            r_out.estimate    <= x_next[DW-1:0];
            r_out.variance    <= r_vprod[DW+FB-1:FB];
            r_out.channel_out <= r_item.channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_est[c] <= X0_RESET;
                r_var[c] <= P0_RESET;
            end
        end else if (i_cmd.upd) begin
            r_est[r_ch] <= x_next[DW-1:0];
            r_var[r_ch] <= r_vprod[DW+FB-1:FB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.upd) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/skf_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module skf_checker import skf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out_item
);

    logic in_acc;
    logic out_held;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;

    // a stalled result stays and does not change
    `SKF_ASSERT(a_out_hold, out_held |=> o_out_valid && $stable(o_out_item), "stalled result changed")

    // one item in work at a time
    `SKF_ASSERT(a_busy_after_acc, in_acc |=> o_in_stall, "input open after an item")

    // a result never appears in the cycle right after an item is taken
    `SKF_ASSERT(a_no_early_out, in_acc |=> !$rose(o_out_valid), "result too early")

    // reset empties the output and opens the input
    `SKF_ASSERT_RST(a_reset_state, !i_rst_n |=> !o_out_valid && !o_in_stall, "bad state after reset")

endmodule

bind scalar_kalman_filter_top skf_checker u_skf_checker (.*);

// File: tb/kalman_checker.sv
`timescale 1ns / 1ps

module kalman_checker import skf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_idx,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_waiting,
    output int                    o_updates
);

    localparam logic [63:0] FULL_SCALE = (64'd1 << DATA_WIDTH) - 64'd1;
    localparam logic [63:0] UNITY_GAIN = 64'd1 << FRAC_BITS;

    logic        [DATA_WIDTH-1:0] q_noise;
    logic        [DATA_WIDTH-1:0] r_noise;
    logic signed [DATA_WIDTH-1:0] est_init;
    logic        [DATA_WIDTH-1:0] var_init;
    logic signed [DATA_WIDTH-1:0] est_mem [CHANNELS];
    logic        [DATA_WIDTH-1:0] var_mem [CHANNELS];

    t_out_item expected_updates[$];
    int        errors  = 0;
    int        updates = 0;

    // One filter step on the mirrored channel state.
    function automatic t_out_item kalman_update(input t_in_item it);
        int                 slot;
        logic        [63:0] p1;
        logic        [63:0] den;
        logic        [63:0] k;
        logic        [63:0] rem;
        logic        [63:0] mag;
        logic        [63:0] step;
        logic        [63:0] p_next;
        logic signed [63:0] x;
        logic signed [63:0] meas;
        logic signed [63:0] diff;
        t_out_item          res;

        slot = int'(it.channel) % CHANNELS;
        if (it.restart) begin
            est_mem[slot] = est_init;
            var_mem[slot] = var_init;
        end
        x    = est_mem[slot];
        meas = it.sample;

        p1 = 64'(var_mem[slot]) + 64'(q_noise);
        if (p1 > FULL_SCALE) p1 = FULL_SCALE;
        den = p1 + 64'(r_noise);
        if (den > FULL_SCALE) den = FULL_SCALE;

        // gain = floor(p1 * 2^F / den), zero if den is zero; one quotient bit per step
        if (den == 64'd0) begin
            k = 64'd0;
        end else if (p1 >= den) begin
            k = UNITY_GAIN;
        end else begin
            rem = p1;
            k   = 64'd0;
            for (int i = 0; i < FRAC_BITS; i++) begin
                rem = rem << 1;
                k   = k << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    k   = k | 64'd1;
                end
            end
        end

        diff = meas - x;
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        step = (mag * k) >> FRAC_BITS;
        if (diff < 0)
            x = x - $signed(step);
        else
            x = x + $signed(step);

        p_next        = (p1 * (UNITY_GAIN - k)) >> FRAC_BITS;
        est_mem[slot] = x[DATA_WIDTH-1:0];
        var_mem[slot] = p_next[DATA_WIDTH-1:0];

        res.estimate    = est_mem[slot];
        res.variance    = var_mem[slot];
        res.channel_out = it.channel;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            q_noise  = Q_RESET;
            r_noise  = R_RESET;
            est_init = X0_RESET;
            var_init = P0_RESET;
            for (int c = 0; c < CHANNELS; c++) begin
                est_mem[c] = X0_RESET;
                var_mem[c] = P0_RESET;
            end
            expected_updates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROC_NOISE: q_noise  = i_cfg_data;
                    CFG_MEAS_NOISE: r_noise  = i_cfg_data;
                    CFG_INIT_EST:   est_init = i_cfg_data;
                    CFG_INIT_VAR:   var_init = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_updates.size() == 0) begin
                    if (errors < 10)
                        $display("ERROR: unexpected result est=%h var=%h ch=%0d",
                                 i_out_item.estimate, i_out_item.variance,
                                 i_out_item.channel_out);
                    errors++;
                end else begin
                    want = expected_updates.pop_front();
                    if (want.estimate !== i_out_item.estimate ||
                        want.variance !== i_out_item.variance ||
                        want.channel_out !== i_out_item.channel_out) begin
                        if (errors < 10)
                            $display({"ERROR: result %0d expected est=%h var=%h ch=%0d,",
                                      " got est=%h var=%h ch=%0d"}, updates,
                                     want.estimate, want.variance, want.channel_out,
                                     i_out_item.estimate, i_out_item.variance,
                                     i_out_item.channel_out);
                        errors++;
                    end
                end
                updates++;
            end

            if (i_in_valid && !i_in_stall)
                expected_updates.push_back(kalman_update(i_in_item));
        end
        o_errors  <= errors;
        o_waiting <= expected_updates.size();
        o_updates <= updates;
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import skf_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_item;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_idx;
    logic [DATA_WIDTH-1:0] cfg_data;

    int errors;
    int waiting;
    int updates;

    bit fast_mode = 1'b0;
    bit hold_req  = 1'b0;
    int items_sent     = 0;
    int settings_used  = 0;
    logic signed [DATA_WIDTH-1:0] track [CHANNELS];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    scalar_kalman_filter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    kalman_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_updates   (updates)
    );

    function automatic t_in_item mk(input logic [DATA_WIDTH-1:0] s, input logic ch,
                                    input logic rs);
        t_in_item it;
        it.sample  = s;
        it.channel = ch;
        it.restart = rs;
        return it;
    endfunction

    // Mostly a slowly drifting signal per channel with small noise, so the
    // filter gets long runs to converge; the rest is extremes and noise.
    function automatic t_in_item rand_item();
        t_in_item it;
        int       sel;
        it.channel = 1'($urandom_range(0, 1));
        it.restart = ($urandom_range(0, 19) == 0);
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
            track[it.channel] = track[it.channel] + $signed($urandom_range(0, 131072))
                                - 65536;
            it.sample = track[it.channel] + $signed($urandom_range(0, 8191)) - 4096;
        end else if (sel == 12) begin
            it.sample = 32'sh7FFF_FFFF;
        end else if (sel == 13) begin
            it.sample = 32'sh8000_0000;
        end else if (sel == 14) begin
            it.sample = track[it.channel];
        end else begin
            it.sample = $urandom;
        end
        return it;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_reg();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 65536);
            3, 4:    return $urandom_range(65536, 1 << 26);
            5:       return DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!(in_valid && !in_stall));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (waiting != 0 || in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
    endtask

    task automatic set_regs(input logic [DATA_WIDTH-1:0] q, input logic [DATA_WIDTH-1:0] r,
                            input logic [DATA_WIDTH-1:0] x0, input logic [DATA_WIDTH-1:0] p0);
        wait_idle();
        write_reg(CFG_PROC_NOISE, q);
        write_reg(CFG_MEAS_NOISE, r);
        write_reg(CFG_INIT_EST, x0);
        write_reg(CFG_INIT_VAR, p0);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // result side: random stall per item, one long hold-off on request
    initial begin : receiver
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                gap      = 400;
                hold_req = 1'b0;
            end else begin
                gap = fast_mode ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    initial begin : watchdog
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [DATA_WIDTH-1:0] r_val;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        for (int c = 0; c < CHANNELS; c++) track[c] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        settings_used = 1;

        // reset defaults: field extremes, both channels, restarts
        send_item(mk(32'h0000_0000, 1'b0, 1'b0));
        send_item(mk(32'h7FFF_FFFF, 1'b0, 1'b0));
        send_item(mk(32'h8000_0000, 1'b1, 1'b0));
        send_item(mk(32'h8000_0000, 1'b0, 1'b0));
        send_item(mk(32'hFFFF_FFFF, 1'b0, 1'b1));
        send_item(mk(32'h0000_0001, 1'b1, 1'b1));
        send_item(mk(32'h7FFF_FFFF, 1'b1, 1'b0));
        send_item(mk(32'h0000_0000, 1'b1, 1'b0));

        // zero denominator: no noise and zero variance, gain forced to zero
        set_regs('0, '0, 32'h1234_5678, '0);
        send_item(mk(32'h7FFF_FFFF, 1'b0, 1'b1));
        send_item(mk(32'h8000_0000, 1'b0, 1'b0));
        send_item(mk(32'h0000_0000, 1'b1, 1'b1));
        send_item(mk(32'hFFFF_FFFB, 1'b1, 1'b0));

        // saturated sums: gain exactly one, full-range differences
        set_regs('1, '1, 32'h8000_0000, '1);
        send_item(mk(32'h7FFF_FFFF, 1'b0, 1'b1));
        send_item(mk(32'h8000_0000, 1'b0, 1'b0));
        send_item(mk(32'h7FFF_FFFF, 1'b1, 1'b1));
        send_item(mk(32'h0001_2345, 1'b1, 1'b0));

        // zero variance, minimal measurement noise
        set_regs('0, 32'd1, 32'h7FFF_FFFF, '0);
        send_item(mk(32'h8000_0000, 1'b0, 1'b1));
        send_item(mk(32'h0000_0000, 1'b1, 1'b1));
        send_item(mk(32'h7FFF_FFFF, 1'b0, 1'b0));

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 0) begin
                set_regs(Q_RESET, R_RESET, X0_RESET, P0_RESET);
            end else begin
                r_val = rand_reg();
                if (r_val == '0) r_val = 1;
                set_regs(rand_reg(), r_val, $urandom, rand_reg());
            end
            fast_mode = (ph == 3 || ph == 7);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < 110; n++) begin
                if (ph == 5 && n == 55) wait_idle();
                send_item(rand_item());
            end
        end

        wait_idle();
        repeat (60) @(posedge clk);
        $display("Run covered %0d items and %0d results over %0d register settings,",
                 items_sent, updates, settings_used);
        $display("with zero and unity gain, saturated sums, restarts and a long output hold-off.");
        if (errors == 0 && waiting == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/skf_pkg.sv
rtl/skf_ctrl.sv
rtl/skf_dp.sv
rtl/scalar_kalman_filter_top.sv
rtl/skf_checker.sv
tb/kalman_checker.sv
tb/tb.sv
